### hdl/multiplexed_seven_segment_clock_assert.svh
// Assertion macros for the multiplexed seven-segment clock.
// Expects i_clk and i_rst_n in the scope of use; no other dependencies.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_CLOCK_ASSERT_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_CLOCK_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define MSSC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MSSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSSC_ASSERT(lbl, ante, cons, msg)
`define MSSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/mssc_pkg.sv
// Package for the multiplexed seven-segment clock: widths, register
// indexes, reset values and digit decode functions. No dependencies.
package mssc_pkg;

    localparam int unsigned RELOAD_W = 16;
    localparam int unsigned DIV_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [RELOAD_W-1:0] t_reload;
    typedef logic [DIV_W-1:0]    t_div;
    typedef logic [6:0]          t_seg;
    typedef logic [3:0]          t_digit;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_RELOAD   = 2'd0,
        CFG_SCAN_RELOAD    = 2'd1,
        CFG_PER_SECOND     = 2'd2,
        CFG_PER_DOT_TOGGLE = 2'd3
    } t_cfg_idx;

    localparam t_reload FIRST_RELOAD_RST = 16'd100;
    localparam t_reload SCAN_RELOAD_RST  = 16'd25;
    localparam t_div    PER_SECOND_RST   = 8'd4;
    localparam t_div    PER_DOT_RST      = 8'd2;

    localparam logic [4:0] HOUR_RST   = 5'd15;
    localparam logic [5:0] MINUTE_RST = 6'd8;
    localparam logic [5:0] SECOND_RST = 6'd50;

    localparam logic [4:0] HOURS_PER_DAY  = 5'd24;
    localparam logic [5:0] UNITS_PER_HOUR = 6'd60;

    localparam t_seg SEG_DARK = 7'h7F;

    // tens digit of a value below 64 by compare chain
    function automatic t_digit tens_of(input logic [5:0] v);
        t_digit t;
        t = 4'd0;
        if (v >= 6'd10) t = 4'd1;
        if (v >= 6'd20) t = 4'd2;
        if (v >= 6'd30) t = 4'd3;
        if (v >= 6'd40) t = 4'd4;
        if (v >= 6'd50) t = 4'd5;
        if (v >= 6'd60) t = 4'd6;
        return t;
    endfunction

    // units digit: subtract ten times the tens digit
    function automatic t_digit units_of(input logic [5:0] v);
        logic [5:0] t;
        logic [5:0] u;
        t = {2'b00, tens_of(v)};
        u = v - {t[2:0], 3'b000} - {t[4:0], 1'b0};
        return u[3:0];
    endfunction

    // active-low segment pattern, lines a..g in bits 0..6
    function automatic t_seg pattern_of(input t_digit d);
        t_seg p;
        case (d)
            4'd0:    p = 7'h40;
            4'd1:    p = 7'h79;
            4'd2:    p = 7'h24;
            4'd3:    p = 7'h30;
            4'd4:    p = 7'h19;
            4'd5:    p = 7'h12;
            4'd6:    p = 7'h02;
            4'd7:    p = 7'h78;
            4'd8:    p = 7'h00;
            4'd9:    p = 7'h10;
            default: p = SEG_DARK;
        endcase
        return p;
    endfunction

endpackage

### hdl/multiplexed_seven_segment_clock.sv
// Multiplexed four-digit seven-segment clock with blinking dot.
// Uses mssc_pkg and multiplexed_seven_segment_clock_assert.svh.
//
// Takes one item per clock: each transfer on the input channel is one base
// tick (i_tick high) or an idle item, and yields exactly one result, held in
// an output register and shown in the cycle after the transfer. All counter
// updates, the time-of-day carry chain and the digit decode are combinational
// and feed that register. o_in_ready drops only while a held result is not
// taken, so with i_out_ready high the block sustains one item every cycle.
// Writing first_reload also restarts the tick counter from the written value.
`include "multiplexed_seven_segment_clock_assert.svh"

module multiplexed_seven_segment_clock (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mssc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                  i_cfg_data,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_tick,
    // results
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [6:0]                   o_segments,
    output logic [3:0]                   o_digit_enables,
    output logic                         o_dot,
    output logic [4:0]                   o_hours,
    output logic [5:0]                   o_minutes,
    output logic [5:0]                   o_seconds
);
    import mssc_pkg::*;

    // configuration registers
    t_reload r_scan_reload;
    t_div    r_per_second;
    t_div    r_per_dot;

    // clock state
    t_reload    r_tick_down, n_tick_down;
    logic [1:0] r_scan_index, n_scan_index;
    t_div       r_sec_div, n_sec_div;
    t_div       r_dot_div, n_dot_div;
    logic [4:0] r_hour, n_hour;
    logic [5:0] r_minute, n_minute;
    logic [5:0] r_second, n_second;
    logic       r_dot, n_dot;
    t_seg       r_seg_latch, n_seg_latch;
    logic [3:0] r_en_latch, n_en_latch;

    // output register
    logic       r_out_valid;
    t_seg       r_out_seg;
    logic [3:0] r_out_en;
    logic       r_out_dot;
    logic [4:0] r_out_hour;
    logic [5:0] r_out_minute;
    logic [5:0] r_out_second;

    logic       in_xfer;
    logic       cfg_xfer;
    logic       expire;
    logic       sec_fire;
    logic       dot_fire;
    t_reload    tick_dec;
    t_div       sec_inc;
    t_div       dot_inc;
    logic [5:0] digit_src;
    t_digit     digit;
    logic [5:0] second_inc;
    logic [5:0] minute_inc;
    logic [4:0] hour_inc;
    logic [5:0] minute_step;
    logic [4:0] hour_step;
    logic       time_ok;
    logic       idle_xfer;

    // handshakes: cfg always ready; inputs accepted while the result slot is empty or being emptied
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;

    // detect expiry of the down counter
    assign tick_dec = r_tick_down - t_reload'(1);
    assign expire   = in_xfer && i_tick && (r_tick_down != '0) && (tick_dec == '0);

    // pick the digit for the current scan position
    always_comb begin
        case (r_scan_index)
            2'd0:    digit_src = {1'b0, r_hour};
            2'd1:    digit_src = {1'b0, r_hour};
            default: digit_src = r_minute;
        endcase
        digit = r_scan_index[0] ? units_of(digit_src) : tens_of(digit_src);
    end

    // dividers count expiries and clear once they reach the threshold
    assign sec_inc  = r_sec_div + t_div'(1);
    assign dot_inc  = r_dot_div + t_div'(1);
    assign sec_fire = sec_inc >= r_per_second;
    assign dot_fire = dot_inc >= r_per_dot;

    // time-of-day carry chain
    always_comb begin
        second_inc  = r_second + 6'd1;
        minute_inc  = r_minute + 6'd1;
        minute_step = r_minute;
        if (second_inc >= UNITS_PER_HOUR) begin
            minute_step = minute_inc;
        end
        hour_step = r_hour;
        hour_inc  = r_hour + 5'd1;
        if (minute_step >= UNITS_PER_HOUR) begin
            hour_step = hour_inc;
        end
    end

    // next state
    always_comb begin
        n_tick_down  = r_tick_down;
        n_scan_index = r_scan_index;
        n_sec_div    = r_sec_div;
        n_dot_div    = r_dot_div;
        n_hour       = r_hour;
        n_minute     = r_minute;
        n_second     = r_second;
        n_dot        = r_dot;
        n_seg_latch  = r_seg_latch;
        n_en_latch   = r_en_latch;
        if (in_xfer && i_tick && (r_tick_down != '0)) begin
            n_tick_down = tick_dec;
        end
        if (expire) begin
            n_tick_down  = r_scan_reload;
            n_en_latch   = 4'hF & ~(4'b0001 << r_scan_index);
            n_seg_latch  = pattern_of(digit);
            n_scan_index = r_scan_index + 2'd1;
            n_sec_div    = sec_fire ? '0 : sec_inc;
            n_dot_div    = dot_fire ? '0 : dot_inc;
            if (sec_fire) begin
                n_second = (second_inc >= UNITS_PER_HOUR) ? 6'd0 : second_inc;
                n_minute = (minute_step >= UNITS_PER_HOUR) ? 6'd0 : minute_step;
                n_hour   = (hour_step >= HOURS_PER_DAY) ? 5'd0 : hour_step;
            end
            if (dot_fire) begin
                n_dot = !r_dot;
            end
        end
        // a first_reload write restarts the counter
        if (cfg_xfer && (t_cfg_idx'(i_cfg_index) == CFG_FIRST_RELOAD)) begin
            n_tick_down = i_cfg_data;
        end
    end

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_reload  <= SCAN_RELOAD_RST;
            r_per_second   <= PER_SECOND_RST;
            r_per_dot      <= PER_DOT_RST;
        end else if (cfg_xfer) begin
            unique case (t_cfg_idx'(i_cfg_index))
                // first_reload only ever loads the counter, handled above
                CFG_FIRST_RELOAD:   ;
                CFG_SCAN_RELOAD:    r_scan_reload  <= i_cfg_data;
                CFG_PER_SECOND:     r_per_second   <= i_cfg_data[DIV_W-1:0];
                CFG_PER_DOT_TOGGLE: r_per_dot      <= i_cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // advance clock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_down  <= FIRST_RELOAD_RST;
            r_scan_index <= '0;
            r_sec_div    <= '0;
            r_dot_div    <= '0;
            r_hour       <= HOUR_RST;
            r_minute     <= MINUTE_RST;
            r_second     <= SECOND_RST;
            r_dot        <= 1'b0;
            r_seg_latch  <= '0;
            r_en_latch   <= '0;
        end else begin
            r_tick_down  <= n_tick_down;
            r_scan_index <= n_scan_index;
            r_sec_div    <= n_sec_div;
            r_dot_div    <= n_dot_div;
            r_hour       <= n_hour;
            r_minute     <= n_minute;
            r_second     <= n_second;
            r_dot        <= n_dot;
            r_seg_latch  <= n_seg_latch;
            r_en_latch   <= n_en_latch;
        end
    end

    // result slot valid: set on input transfer, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // capture the result of each transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_seg    <= n_seg_latch;
            r_out_en     <= n_en_latch;
            r_out_dot    <= n_dot;
            r_out_hour   <= n_hour;
            r_out_minute <= n_minute;
            r_out_second <= n_second;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_segments      = r_out_seg;
    assign o_digit_enables = r_out_en;
    assign o_dot           = r_out_dot;
    assign o_hours         = r_out_hour;
    assign o_minutes       = r_out_minute;
    assign o_seconds       = r_out_second;

    // helper terms for the checks below
    assign time_ok   = (r_hour < HOURS_PER_DAY) && (r_minute < UNITS_PER_HOUR) &&
                       (r_second < UNITS_PER_HOUR);
    assign idle_xfer = in_xfer && !i_tick;

    // time of day stays in range
    `MSSC_ASSERT(a_time_range, 1'b1, time_ok, "time of day out of range")
    // each expiry steps the scan to the next digit
    `MSSC_ASSERT(a_scan_step, expire, n_scan_index == r_scan_index + 2'd1, "no scan step")
    // after an expiry exactly one digit is enabled
    `MSSC_ASSERT_NEXT(a_one_digit, expire, $countones(r_en_latch) == 3, "not one digit enabled")
    // an idle item leaves the seconds and the dot alone
    `MSSC_ASSERT_NEXT(a_idle_hold, idle_xfer, $stable({r_second, r_dot}), "idle moved time")
    // a held result blocks new transfers
    `MSSC_ASSERT(a_stall_block, r_out_valid && !i_out_ready, !in_xfer, "transfer into full slot")

endmodule
